// ===== rtl/core/mas_pkg.sv =====
// Package for the mailbox address splitter: types, character codes and helpers.
// Used by mailbox_address_splitter; depends on nothing.
package mas_pkg;

  // Comment nesting counter width; depth saturates at all ones.
  localparam int DepthBits = 8;

  typedef enum logic [1:0] {
    CTX_TOP     = 2'd0,
    CTX_COMMENT = 2'd1,
    CTX_ANGLE   = 2'd2
  } ctx_t;

  typedef enum logic [1:0] {
    DEST_DROP    = 2'd0,
    DEST_DISPLAY = 2'd1,
    DEST_COMMENT = 2'd2,
    DEST_ADDR    = 2'd3
  } dest_t;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_OPEN_QUOTE = 3'd1,
    STAT_OPEN_CMT   = 3'd2,
    STAT_OPEN_ANGLE = 3'd3,
    STAT_NO_ADDR    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CAUSE_NONE      = 2'd0,
    CAUSE_BACKSLASH = 2'd1,
    CAUSE_COMMA     = 2'd2
  } cause_t;

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChLAngle = 8'h3C;
  localparam logic [7:0] ChRAngle = 8'h3E;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;

  // ASCII whitespace: tab through carriage return, and space
  function automatic logic is_blank(input logic [7:0] b);
    return (b == ChSpace) || ((b >= ChTab) && (b <= ChCr));
  endfunction

endpackage

// ===== rtl/core/mailbox_address_splitter.sv =====
// Mailbox address splitter top level: byte tagger with input and result registers.
// Depends on mas_pkg.
//
// Takes one byte of a mailbox string per word and returns one tagged word per byte,
// naming the text it belongs to (display name, comment, address spec or none), with
// error status and the address-from-display flag on the final byte. One byte is
// accepted every cycle while out_stall does not hold the result register. A byte is
// held in the input register and its result in the result register; the parse-state
// update between the two is combinational. While the result register waits on
// out_stall, one more byte is taken into the input register.
module mailbox_address_splitter
  import mas_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] dest,
  output logic       out_last,
  output logic [2:0] status,
  output logic [1:0] abort_cause,
  output logic       addr_from_display
);

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  // parse state
  ctx_t                 context_q;
  logic                 in_quote;
  logic [DepthBits-1:0] comment_depth;
  logic                 escape_pending;
  logic                 stopped;
  logic                 display_nonblank;
  logic                 addr_nonblank;

  ctx_t                 context_next;
  logic                 in_quote_next;
  logic [DepthBits-1:0] comment_depth_next;
  logic                 escape_pending_next;
  logic                 stopped_next;
  logic                 display_nonblank_next;
  logic                 addr_nonblank_next;

  logic [7:0] res_byte;
  dest_t      res_dest;
  dest_t      ctx_dest;
  status_t    res_status;
  cause_t     res_cause;
  logic       res_from_disp;

  logic accept_in;
  logic adv;

  assign adv       = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !adv;
  assign accept_in = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept_in || (s1_valid && !adv);
    end
    if (accept_in) begin
      s1_byte <= in_byte;
      s1_last <= in_last;
    end
  end

  always_comb begin
    case (context_q)
      CTX_COMMENT: ctx_dest = DEST_COMMENT;
      CTX_ANGLE:   ctx_dest = DEST_ADDR;
      default:     ctx_dest = DEST_DISPLAY;
    endcase
  end

  always_comb begin
    context_next          = context_q;
    in_quote_next         = in_quote;
    comment_depth_next    = comment_depth;
    escape_pending_next   = escape_pending;
    stopped_next          = stopped;
    display_nonblank_next = display_nonblank;
    addr_nonblank_next    = addr_nonblank;
    res_byte              = s1_byte;
    res_dest              = DEST_DROP;
    res_cause             = CAUSE_NONE;
    res_status            = STAT_OK;
    res_from_disp         = 1'b0;

    if (stopped) begin
      res_dest = DEST_DROP;
    end else if (s1_byte == ChNul) begin
      // terminator inside the string: drop the rest
      stopped_next = 1'b1;
      if (escape_pending) begin
        res_cause = CAUSE_BACKSLASH;
      end
      escape_pending_next = 1'b0;
    end else if (escape_pending) begin
      res_dest            = ctx_dest;
      escape_pending_next = 1'b0;
    end else begin
      case (context_q)
        CTX_COMMENT: begin
          res_dest = DEST_COMMENT;
          if (s1_byte == ChLParen) begin
            if (comment_depth != '1) begin
              comment_depth_next = DepthBits'(comment_depth + 1'b1);
            end
          end else if (s1_byte == ChRParen) begin
            if (comment_depth <= DepthBits'(1)) begin
              comment_depth_next = '0;
              context_next       = CTX_TOP;
              res_byte           = ChSpace;
            end else begin
              comment_depth_next = DepthBits'(comment_depth - 1'b1);
            end
          end else if (s1_byte == ChBslash) begin
            escape_pending_next = 1'b1;
          end
        end
        CTX_ANGLE: begin
          res_dest = DEST_ADDR;
          if (s1_byte == ChDquote) begin
            in_quote_next = !in_quote;
          end else if (s1_byte == ChRAngle && !in_quote) begin
            context_next = CTX_TOP;
            res_dest     = DEST_DROP;
          end else if (s1_byte == ChBslash) begin
            escape_pending_next = 1'b1;
          end
        end
        default: begin
          res_dest = DEST_DISPLAY;
          if (s1_byte == ChDquote) begin
            in_quote_next = !in_quote;
          end else if (s1_byte == ChLParen && !in_quote) begin
            context_next       = CTX_COMMENT;
            comment_depth_next = DepthBits'(1);
            res_dest           = DEST_DROP;
          end else if (s1_byte == ChLAngle && !in_quote) begin
            context_next = CTX_ANGLE;
            res_dest     = DEST_DROP;
          end else if (s1_byte == ChBslash) begin
            escape_pending_next = 1'b1;
          end else if (s1_byte == ChComma && !in_quote) begin
            stopped_next = 1'b1;
            res_cause    = CAUSE_COMMA;
            res_dest     = DEST_DROP;
          end
        end
      endcase
    end

    // escape cut off by the end of the string
    if (escape_pending_next && s1_last && !stopped_next) begin
      stopped_next        = 1'b1;
      res_cause           = CAUSE_BACKSLASH;
      escape_pending_next = 1'b0;
    end

    if (res_dest == DEST_DISPLAY && !is_blank(res_byte)) begin
      display_nonblank_next = 1'b1;
    end
    if (res_dest == DEST_ADDR && !is_blank(res_byte)) begin
      addr_nonblank_next = 1'b1;
    end
    if (res_dest == DEST_DROP) begin
      res_byte = 8'h00;
    end

    if (s1_last) begin
      if (in_quote_next) begin
        res_status = STAT_OPEN_QUOTE;
      end else if (context_next == CTX_COMMENT) begin
        res_status = STAT_OPEN_CMT;
      end else if (context_next == CTX_ANGLE) begin
        res_status = STAT_OPEN_ANGLE;
      end else if (!addr_nonblank_next) begin
        if (!display_nonblank_next) begin
          res_status = STAT_NO_ADDR;
        end else begin
          res_from_disp = 1'b1;
        end
      end
      // start the next string from scratch
      context_next          = CTX_TOP;
      in_quote_next         = 1'b0;
      comment_depth_next    = '0;
      escape_pending_next   = 1'b0;
      stopped_next          = 1'b0;
      display_nonblank_next = 1'b0;
      addr_nonblank_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      context_q        <= CTX_TOP;
      in_quote         <= 1'b0;
      comment_depth    <= '0;
      escape_pending   <= 1'b0;
      stopped          <= 1'b0;
      display_nonblank <= 1'b0;
      addr_nonblank    <= 1'b0;
    end else if (adv) begin
      context_q        <= context_next;
      in_quote         <= in_quote_next;
      comment_depth    <= comment_depth_next;
      escape_pending   <= escape_pending_next;
      stopped          <= stopped_next;
      display_nonblank <= display_nonblank_next;
      addr_nonblank    <= addr_nonblank_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (adv) begin
      out_byte          <= res_byte;
      dest              <= res_dest;
      out_last          <= s1_last;
      status            <= res_status;
      abort_cause       <= res_cause;
      addr_from_display <= res_from_disp;
    end
  end

`ifndef NO_ASSERTIONS
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && dest == DEST_DROP |-> out_byte == 8'h00)
    else $error("dropped word carries a nonzero byte");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> status == STAT_OK && !addr_from_display)
    else $error("status reported before the final byte");

  a_reset_after_last: assert property (@(posedge clk) disable iff (rst)
    adv && s1_last |=> context_q == CTX_TOP && comment_depth == '0 && !stopped
                       && !in_quote && !escape_pending)
    else $error("parse state not cleared after the final byte");

  a_stopped_drops: assert property (@(posedge clk) disable iff (rst)
    adv && stopped |=> dest == DEST_DROP && abort_cause == CAUSE_NONE)
    else $error("byte after an abort was not dropped");

  a_depth_ctx: assert property (@(posedge clk) disable iff (rst)
    (context_q == CTX_COMMENT) == (comment_depth != '0))
    else $error("comment depth disagrees with context");
`endif

endmodule

// ===== dv/testbench.sv =====
// Testbench for mailbox_address_splitter: drives byte strings under random idling and checks
// every tagged word against a scoreboard with its own parse-state predictor.
// Depends on mas_pkg and the mailbox_address_splitter RTL.
module testbench;
  import mas_pkg::*;

  localparam int WatchdogLimit = 2000;

  typedef struct packed {
    logic [7:0] data;
    dest_t      dst;
    logic       fin;
    status_t    stat;
    cause_t     cause;
    logic       from_disp;
  } tag_word_t;

  class tag_scoreboard;
    tag_word_t        queued_tags[$];
    int               mismatches;
    ctx_t             ctx;
    logic             quoted;
    logic [DepthBits-1:0] depth;
    logic             esc;
    logic             stopped;
    logic             disp_seen;
    logic             addr_seen;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      ctx = CTX_TOP;
      quoted = 1'b0;
      depth = '0;
      esc = 1'b0;
      stopped = 1'b0;
      disp_seen = 1'b0;
      addr_seen = 1'b0;
    endfunction

    function bit blank(logic [7:0] b);
      return (b == ChSpace) || ((b >= ChTab) && (b <= ChCr));
    endfunction

    function int waiting();
      return queued_tags.size();
    endfunction

    // Advance the parse state by one accepted byte and queue the word it should produce.
    function void tag_byte(logic [7:0] b, logic fin);
      tag_word_t w;
      logic [7:0] ob;
      dest_t      d;
      cause_t     c;
      status_t    s;
      logic       fd;
      ob = b;
      d = DEST_DROP;
      c = CAUSE_NONE;
      s = STAT_OK;
      fd = 1'b0;
      if (!stopped) begin
        if (b == ChNul) begin
          stopped = 1'b1;
          if (esc) c = CAUSE_BACKSLASH;
          esc = 1'b0;
        end else if (esc) begin
          case (ctx)
            CTX_COMMENT: d = DEST_COMMENT;
            CTX_ANGLE:   d = DEST_ADDR;
            default:     d = DEST_DISPLAY;
          endcase
          esc = 1'b0;
        end else begin
          case (ctx)
            CTX_COMMENT: begin
              d = DEST_COMMENT;
              if (b == ChLParen) begin
                if (depth != {DepthBits{1'b1}}) depth = depth + 1'b1;
              end else if (b == ChRParen) begin
                if (depth <= 1) begin
                  depth = '0;
                  ctx = CTX_TOP;
                  ob = ChSpace;
                end else begin
                  depth = depth - 1'b1;
                end
              end else if (b == ChBslash) begin
                esc = 1'b1;
              end
            end
            CTX_ANGLE: begin
              d = DEST_ADDR;
              if (b == ChDquote) begin
                quoted = !quoted;
              end else if (b == ChRAngle && !quoted) begin
                ctx = CTX_TOP;
                d = DEST_DROP;
              end else if (b == ChBslash) begin
                esc = 1'b1;
              end
            end
            default: begin
              d = DEST_DISPLAY;
              if (b == ChDquote) begin
                quoted = !quoted;
              end else if (b == ChLParen && !quoted) begin
                ctx = CTX_COMMENT;
                depth = DepthBits'(1);
                d = DEST_DROP;
              end else if (b == ChLAngle && !quoted) begin
                ctx = CTX_ANGLE;
                d = DEST_DROP;
              end else if (b == ChBslash) begin
                esc = 1'b1;
              end else if (b == ChComma && !quoted) begin
                stopped = 1'b1;
                c = CAUSE_COMMA;
                d = DEST_DROP;
              end
            end
          endcase
        end
      end
      // an escape cut off by the end of the string aborts
      if (esc && fin && !stopped) begin
        stopped = 1'b1;
        c = CAUSE_BACKSLASH;
        esc = 1'b0;
      end
      if (d == DEST_DISPLAY && !blank(ob)) disp_seen = 1'b1;
      if (d == DEST_ADDR && !blank(ob)) addr_seen = 1'b1;
      if (d == DEST_DROP) ob = 8'h00;
      if (fin) begin
        if (quoted) s = STAT_OPEN_QUOTE;
        else if (ctx == CTX_COMMENT) s = STAT_OPEN_CMT;
        else if (ctx == CTX_ANGLE) s = STAT_OPEN_ANGLE;
        else if (!addr_seen) begin
          if (!disp_seen) s = STAT_NO_ADDR;
          else fd = 1'b1;
        end
        clear();
      end
      w.data = ob;
      w.dst = d;
      w.fin = fin;
      w.stat = s;
      w.cause = c;
      w.from_disp = fd;
      queued_tags.push_back(w);
    endfunction

    task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      $display("mismatch in %s: got %h, expected %h", what, got, want);
      mismatches++;
    endtask

    task check_tag(logic [7:0] b, logic [1:0] d, logic fin, logic [2:0] st, logic [1:0] c,
                   logic fd);
      tag_word_t w;
      if (queued_tags.size() == 0) begin
        report_mismatch("unexpected word", b, 8'h00);
        return;
      end
      w = queued_tags.pop_front();
      if (b !== w.data) report_mismatch("out_byte", b, w.data);
      if (d !== w.dst) report_mismatch("dest", d, w.dst);
      if (fin !== w.fin) report_mismatch("out_last", fin, w.fin);
      if (st !== w.stat) report_mismatch("status", st, w.stat);
      if (c !== w.cause) report_mismatch("abort_cause", c, w.cause);
      if (fd !== w.from_disp) report_mismatch("addr_from_display", fd, w.from_disp);
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic [1:0] dest;
  logic       out_last;
  logic [2:0] status;
  logic [1:0] abort_cause;
  logic       addr_from_display;

  tag_scoreboard sb;
  bit            calm = 1'b0;
  int            quiet_cycles = 0;
  logic [7:0]    mailbox_text[$];

  mailbox_address_splitter uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte), .dest(dest),
    .out_last(out_last), .status(status), .abort_cause(abort_cause),
    .addr_from_display(addr_from_display)
  );

  always #10 clk = ~clk;

  // Decide acceptance at the falling edge, where every input and output is settled.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.tag_byte(in_byte, in_last);
      if (out_valid && !out_stall)
        sb.check_tag(out_byte, dest, out_last, status, abort_cause, addr_from_display);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("FAIL mailbox_address_splitter");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver: stall in random bursts until the closing stretch.
  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Call at a rising edge; returns at the rising edge that takes the word.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    bit taken;
    if (!calm && $urandom_range(0, 11) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_last <= fin;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic send_mailbox();
    for (int i = 0; i < mailbox_text.size(); i++)
      send_byte(mailbox_text[i], i == mailbox_text.size() - 1);
  endtask

  function automatic logic [7:0] text_char();
    case ($urandom_range(0, 19))
      0, 1: return ChSpace;
      2: return 8'($urandom_range(8'h80, 8'hFF));
      3: return 8'($urandom_range(ChTab, ChCr));
      4: begin
        case ($urandom_range(0, 6))
          0: return ChLParen;
          1: return ChRParen;
          2: return ChLAngle;
          3: return ChRAngle;
          4: return ChComma;
          5: return ChDquote;
          default: return 8'h40;
        endcase
      end
      default: return 8'($urandom_range(8'h61, 8'h7A));
    endcase
  endfunction

  function automatic void add_text(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 11) == 0) mailbox_text.push_back(ChBslash);
      mailbox_text.push_back(text_char());
    end
  endfunction

  // Mostly name, comment and angle address in order; the rest truncated or raw noise.
  function automatic void make_mailbox();
    int shape;
    mailbox_text.delete();
    shape = $urandom_range(0, 9);
    if (shape < 8) begin
      if ($urandom_range(0, 1) != 0) begin
        if ($urandom_range(0, 2) == 0) begin
          mailbox_text.push_back(ChDquote);
          add_text($urandom_range(1, 6));
          mailbox_text.push_back(ChDquote);
        end else begin
          add_text($urandom_range(1, 8));
        end
        if ($urandom_range(0, 1) != 0) mailbox_text.push_back(ChSpace);
      end
      if ($urandom_range(0, 2) == 0) begin
        mailbox_text.push_back(ChLParen);
        add_text($urandom_range(1, 4));
        if ($urandom_range(0, 1) != 0) begin
          mailbox_text.push_back(ChLParen);
          add_text($urandom_range(1, 3));
          mailbox_text.push_back(ChRParen);
        end
        mailbox_text.push_back(ChRParen);
      end
      if ($urandom_range(0, 3) != 0) begin
        mailbox_text.push_back(ChLAngle);
        add_text($urandom_range(1, 8));
        mailbox_text.push_back(ChRAngle);
      end else begin
        add_text($urandom_range(1, 6));
      end
      if (shape == 7) begin
        repeat ($urandom_range(1, 3))
          if (mailbox_text.size() > 1) void'(mailbox_text.pop_back());
      end
    end else begin
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 5) == 0) mailbox_text.push_back(ChNul);
        else mailbox_text.push_back(8'($urandom_range(0, 255)));
      end
    end
  endfunction

  initial begin : stimulus
    int  sent;
    bit  deep_done;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_byte = 8'h00;
    in_last = 1'b0;
    sent = 0;
    deep_done = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_text("N<\"a>\"\\x>");   // quoted '>' and escape inside the angle address
    send_text("(\\)(()");        // escaped paren and nesting, comment left open
    send_text("x\\");            // backslash as the final byte
    send_text("a,b");            // top-level comma aborts
    send_byte(8'hFF, 1'b0);      // zero byte straight after a backslash
    send_byte(ChBslash, 1'b0);
    send_byte(ChNul, 1'b0);
    send_byte(8'h41, 1'b1);
    send_text(" ");              // nothing but whitespace: no address
    send_text("\"q");            // quote left open

    while (sent < 600) begin
      if (sent >= 20 && !deep_done) begin
        // overflow the nesting counter, then close exactly as many as it can hold
        mailbox_text.delete();
        repeat (258) mailbox_text.push_back(ChLParen);
        repeat (255) mailbox_text.push_back(ChRParen);
        mailbox_text.push_back(8'h61);
        send_mailbox();
        sent += mailbox_text.size();
        deep_done = 1'b1;
      end
      make_mailbox();
      send_mailbox();
      sent += mailbox_text.size();
      if (sent >= 560) calm = 1'b1;
    end
    in_valid <= 1'b0;

    while (sb.waiting() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASS mailbox_address_splitter");
    end else begin
      $display("FAIL mailbox_address_splitter");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/mas_pkg.sv
rtl/core/mailbox_address_splitter.sv
dv/testbench.sv
